// ===== sv/tppm_pkg.sv =====
// Shared types, character codes and helper functions of the text pixel measurer.
`timescale 1ns / 1ps
`default_nettype none
package tppm_pkg;

  // Fixed field widths
  localparam int unsigned CHAR_BITS  = 8;
  localparam int unsigned FIELD_BITS = 16;   // x_position, bytes_consumed, widest_line
  localparam int unsigned POSITION_BITS = FIELD_BITS;  // position and byte count
  localparam int unsigned LIMIT_BITS = 16;   // pixel_limit
  localparam int unsigned TAB_BITS   = 12;   // tab_stop_pixels
  localparam int unsigned INC_BITS   = 12;   // per-byte increment (tab or up to three glyphs)
  localparam int unsigned CAUSE_BITS = 2;
  localparam int unsigned IN_TDATA_BITS  = 48;
  localparam int unsigned OUT_TDATA_BITS = 48;
  localparam int unsigned GLYPH_DEPTH    = 256;
  localparam int unsigned CFG_INDEX_BITS = 2;

  // Opcodes
  localparam logic OP_TABLE_WRITE = 1'b0;
  localparam logic OP_TEXT        = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_TAB_STOP = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INTL     = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WIDE     = 2'd2;

  // Character codes
  localparam logic [CHAR_BITS-1:0] CH_TAB        = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_NEWLINE    = 8'h0A;
  localparam logic [CHAR_BITS-1:0] CH_SPACE      = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_AT         = 8'h40;
  localparam logic [CHAR_BITS-1:0] CH_CARET      = 8'h5E;
  localparam logic [CHAR_BITS-1:0] CH_LOWER_H    = 8'h68;
  localparam logic [CHAR_BITS-1:0] CH_TILDE      = 8'h7E;
  localparam logic [CHAR_BITS-1:0] CH_INTL_FIRST = 8'd160;

  typedef enum logic [CAUSE_BITS-1:0] {
    CAUSE_NEWLINE = 2'd0,
    CAUSE_LIMIT   = 2'd1,
    CAUSE_RANGE   = 2'd2
  } stop_cause_e;

  typedef enum logic [2:0] {
    KIND_GLYPH,    // one table lookup of the byte itself
    KIND_SPACE,    // space, optionally doubled
    KIND_HEX,      // two hex digits plus 'h'
    KIND_CONTROL,  // caret plus letter
    KIND_TAB,
    KIND_NEWLINE
  } byte_kind_e;

  typedef struct packed {
    logic        table_wr;   // write glyph table from the input transfer
    logic        load;       // latch a text byte from the input transfer
    logic        rd;         // issue a glyph table read
    logic [1:0]  step;       // which lookup of the byte
    logic        acc;        // add the returned width
    logic        div_start;  // clear the tab remainder
    logic        div_step;   // one remainder bit
    logic        commit;     // apply the new position unless over the limit
    logic        finish;     // close the line and load the result register
    stop_cause_e cause;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       line_done;
    logic       range_end;
    byte_kind_e kind;
    logic       div_last;
    logic       over_limit;
    logic       out_busy;
  } dp_status_t;

  function automatic logic [CHAR_BITS-1:0] hex_ascii(input logic [3:0] nib);
    logic [CHAR_BITS-1:0] ch;
    case (nib)
      4'h0: ch = 8'h30;
      4'h1: ch = 8'h31;
      4'h2: ch = 8'h32;
      4'h3: ch = 8'h33;
      4'h4: ch = 8'h34;
      4'h5: ch = 8'h35;
      4'h6: ch = 8'h36;
      4'h7: ch = 8'h37;
      4'h8: ch = 8'h38;
      4'h9: ch = 8'h39;
      4'hA: ch = 8'h41;
      4'hB: ch = 8'h42;
      4'hC: ch = 8'h43;
      4'hD: ch = 8'h44;
      4'hE: ch = 8'h45;
      4'hF: ch = 8'h46;
      default: ch = 8'h30;
    endcase
    return ch;
  endfunction

endpackage
`default_nettype wire

// ===== sv/tppm_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module tppm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== sv/tppm_ctrl.sv =====
// Sequencer of the text pixel measurer: walks each byte through lookup, tab and commit steps.
`timescale 1ns / 1ps
`default_nettype none
module tppm_ctrl
  import tppm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       in_opcode_i,
  output logic            in_ready_o,
  input  wire dp_status_t sts_i,
  output ctrl_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_READ,
    ST_ACC,
    ST_DIV,
    ST_ADD,
    ST_FIN
  } state_e;

  state_e      state_q, state_d;
  logic [1:0]  step_q, step_d;
  stop_cause_e cause_q, cause_d;
  logic [1:0]  last_step;

  // Number of table lookups per byte kind, minus one
  always_comb begin
    case (sts_i.kind)
      KIND_HEX:     last_step = 2'd2;
      KIND_CONTROL: last_step = 2'd1;
      default:      last_step = 2'd0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cause_d = cause_q;
    cmd_o   = '0;
    cmd_o.step  = step_q;
    cmd_o.cause = cause_q;
    in_ready_o  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_opcode_i == OP_TEXT) begin
            cmd_o.load = 1'b1;
            state_d    = ST_DECIDE;
          end else begin
            cmd_o.table_wr = 1'b1;
          end
        end
      end
      ST_DECIDE: begin
        step_d = 2'd0;
        if (sts_i.line_done) begin
          state_d = ST_IDLE;
        end else if (sts_i.range_end) begin
          cause_d = CAUSE_RANGE;
          state_d = ST_FIN;
        end else if (sts_i.kind == KIND_NEWLINE) begin
          cause_d = CAUSE_NEWLINE;
          state_d = ST_FIN;
        end else if (sts_i.kind == KIND_TAB) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (step_q == last_step) begin
          state_d = ST_ADD;
        end else begin
          step_d  = step_q + 2'd1;
          state_d = ST_READ;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        cmd_o.commit = 1'b1;
        if (sts_i.over_limit) begin
          cause_d = CAUSE_LIMIT;
          state_d = ST_FIN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= 2'd0;
      cause_q <= CAUSE_NEWLINE;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cause_q <= cause_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/tppm_dp.sv =====
// Datapath of the text pixel measurer: glyph table, position, tab remainder and result register.
`timescale 1ns / 1ps
`default_nettype none
module tppm_dp
  import tppm_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire ctrl_cmd_t                 cmd_i,
  output dp_status_t                     sts_o,
  // input fields
  input  wire logic [CHAR_BITS-1:0]      table_index_i,
  input  wire logic [CHAR_BITS-1:0]      table_width_i,
  input  wire logic [CHAR_BITS-1:0]      text_byte_i,
  input  wire logic                      line_start_i,
  input  wire logic                      limit_mode_i,
  input  wire logic [LIMIT_BITS-1:0]     pixel_limit_i,
  input  wire logic                      range_end_i,
  // configuration writes
  input  wire logic                      cfg_we_i,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire logic [TAB_BITS-1:0]       cfg_data_i,
  // result
  input  wire logic                      out_ready_i,
  output logic                           out_valid_o,
  output logic [FIELD_BITS-1:0]          out_x_o,
  output logic [FIELD_BITS-1:0]          out_bytes_o,
  output logic [FIELD_BITS-1:0]          out_widest_o,
  output stop_cause_e                    out_cause_o
);

  localparam int unsigned BIT_IDX_BITS = (POSITION_BITS > 1) ? $clog2(POSITION_BITS) : 1;
  localparam int unsigned ADD_BITS =
      ((POSITION_BITS > INC_BITS) ? POSITION_BITS : INC_BITS) + 1;
  localparam int unsigned CMP_BITS =
      (POSITION_BITS > LIMIT_BITS) ? POSITION_BITS : LIMIT_BITS;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
  localparam logic [BIT_IDX_BITS-1:0]  TOP_BIT = BIT_IDX_BITS'(POSITION_BITS - 1);

  // configuration
  logic [TAB_BITS-1:0] tab_q;
  logic                intl_q;
  logic                wide_q;

  // latched byte
  logic [CHAR_BITS-1:0]  byte_q;
  logic                  limit_mode_q;
  logic [LIMIT_BITS-1:0] pixel_limit_q;
  logic                  range_end_q;

  // line state
  logic [POSITION_BITS-1:0] x_q, x_d;
  logic [POSITION_BITS-1:0] count_q, count_d;
  logic [POSITION_BITS-1:0] widest_q, widest_d;
  logic                     line_done_q, line_done_d;

  // increment and tab remainder
  logic [INC_BITS-1:0]     sum_q, sum_d;
  logic [TAB_BITS-1:0]     rem_q, rem_d;
  logic [BIT_IDX_BITS-1:0] bit_q, bit_d;

  // result register
  logic                  out_valid_q;
  logic [FIELD_BITS-1:0] out_x_q, out_bytes_q, out_widest_q;
  stop_cause_e           out_cause_q;

  byte_kind_e          kind;
  logic [CHAR_BITS-1:0] rd_addr;
  logic [CHAR_BITS-1:0] rd_data;
  logic [TAB_BITS-1:0]  tab_eff;
  logic [TAB_BITS:0]    rem_shift;
  logic [TAB_BITS-1:0]  rem_next;
  logic [INC_BITS-1:0]  add_width;
  logic [ADD_BITS-1:0]  x_sum;
  logic [POSITION_BITS-1:0] x_next;
  logic                 over_limit;

  tppm_ram #(
    .WIDTH (CHAR_BITS),
    .DEPTH (GLYPH_DEPTH)
  ) u_glyph_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.table_wr),
    .waddr_i (table_index_i),
    .wdata_i (table_width_i),
    .re_i    (cmd_i.rd),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Classify the latched byte
  always_comb begin
    if (byte_q == CH_TAB) begin
      kind = KIND_TAB;
    end else if (byte_q == CH_NEWLINE) begin
      kind = KIND_NEWLINE;
    end else if (byte_q > CH_SPACE && byte_q <= CH_TILDE) begin
      kind = KIND_GLYPH;
    end else if (byte_q >= CH_INTL_FIRST && intl_q) begin
      kind = KIND_GLYPH;
    end else if (byte_q > CH_TILDE) begin
      kind = KIND_HEX;
    end else if (byte_q == CH_SPACE) begin
      kind = KIND_SPACE;
    end else begin
      kind = KIND_CONTROL;
    end
  end

  // Lookup address per kind and step
  always_comb begin
    case (kind)
      KIND_SPACE: rd_addr = CH_SPACE;
      KIND_HEX: begin
        case (cmd_i.step)
          2'd0:    rd_addr = hex_ascii(byte_q[7:4]);
          2'd1:    rd_addr = hex_ascii(byte_q[3:0]);
          default: rd_addr = CH_LOWER_H;
        endcase
      end
      KIND_CONTROL: begin
        if (cmd_i.step == 2'd0) begin
          rd_addr = CH_CARET;
        end else begin
          rd_addr = byte_q + CH_AT;
        end
      end
      default: rd_addr = byte_q;
    endcase
  end

  // Tab remainder: one dividend bit per step, restoring
  assign tab_eff   = (tab_q == '0) ? TAB_BITS'(1) : tab_q;
  assign rem_shift = {rem_q, x_q[bit_q]};
  assign rem_next  = (rem_shift >= {1'b0, tab_eff})
                   ? TAB_BITS'(rem_shift - {1'b0, tab_eff})
                   : rem_shift[TAB_BITS-1:0];

  // Width of the returned glyph, doubled for a wide space
  assign add_width = (kind == KIND_SPACE && wide_q)
                   ? {{(INC_BITS-CHAR_BITS-1){1'b0}}, rd_data, 1'b0}
                   : INC_BITS'(rd_data);

  // Saturating new position and limit check
  assign x_sum  = ADD_BITS'(x_q) + ADD_BITS'(sum_q);
  assign x_next = (x_sum > ADD_BITS'(POS_MAX)) ? POS_MAX : x_sum[POSITION_BITS-1:0];
  assign over_limit = limit_mode_q && (CMP_BITS'(x_next) > CMP_BITS'(pixel_limit_q));

  always_comb begin
    x_d         = x_q;
    count_d     = count_q;
    widest_d    = widest_q;
    line_done_d = line_done_q;
    sum_d       = sum_q;
    rem_d       = rem_q;
    bit_d       = bit_q;
    if (cmd_i.load) begin
      sum_d = '0;
      if (line_start_i) begin
        x_d         = '0;
        count_d     = '0;
        line_done_d = 1'b0;
      end
    end
    if (cmd_i.acc) begin
      sum_d = sum_q + add_width;
    end
    if (cmd_i.div_start) begin
      rem_d = '0;
      bit_d = TOP_BIT;
    end
    if (cmd_i.div_step) begin
      rem_d = rem_next;
      bit_d = bit_q - BIT_IDX_BITS'(1);
      if (bit_q == '0) begin
        sum_d = INC_BITS'(tab_eff - rem_next);
      end
    end
    if (cmd_i.commit && !over_limit) begin
      x_d = x_next;
      if (count_q != POS_MAX) begin
        count_d = count_q + POSITION_BITS'(1);
      end
    end
    if (cmd_i.finish) begin
      if (x_q > widest_q) begin
        widest_d = x_q;
      end
      line_done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_q       <= TAB_BITS'(8);
      intl_q      <= 1'b0;
      wide_q      <= 1'b0;
      x_q         <= '0;
      count_q     <= '0;
      widest_q    <= '0;
      line_done_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_TAB_STOP: tab_q  <= cfg_data_i;
          REG_INTL:     intl_q <= cfg_data_i[0];
          REG_WIDE:     wide_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      x_q         <= x_d;
      count_q     <= count_d;
      widest_q    <= widest_d;
      line_done_q <= line_done_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q        <= text_byte_i;
      limit_mode_q  <= limit_mode_i;
      pixel_limit_q <= pixel_limit_i;
      range_end_q   <= range_end_i;
    end
    sum_q <= sum_d;
    rem_q <= rem_d;
    bit_q <= bit_d;
    if (cmd_i.finish) begin
      out_x_q      <= FIELD_BITS'(x_q);
      out_bytes_q  <= FIELD_BITS'(count_q);
      out_widest_q <= FIELD_BITS'(widest_d);
      out_cause_q  <= cmd_i.cause;
    end
  end

  assign sts_o.line_done  = line_done_q;
  assign sts_o.range_end  = range_end_q;
  assign sts_o.kind       = kind;
  assign sts_o.div_last   = (bit_q == '0);
  assign sts_o.over_limit = over_limit;
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_x_o      = out_x_q;
  assign out_bytes_o  = out_bytes_q;
  assign out_widest_o = out_widest_q;
  assign out_cause_o  = out_cause_q;

endmodule
`default_nettype wire

// ===== sv/text_pixel_position_measure_core.sv =====
// Top level of the text pixel measurer: ports, sequencer and datapath.
//
// Use: a stream of items enters on s_axis. tuser set marks a text byte, clear a
// glyph width table write (index and width in tdata). Table writes give no
// result. Text bytes walk the current line; a line is armed by line_start and
// closed by a newline, by tlast (range end, byte not counted) or, in limit
// mode, by a byte that would pass pixel_limit. Each close gives one result on
// m_axis: position, byte count, widest line so far and the stop cause in
// tuser.
// Bytes are handled one at a time. A glyph or space needs one table lookup, a
// control byte two and a hex byte three, each a read and an accumulate step
// through the registered glyph RAM port; a tab instead runs the bit-serial
// remainder unit over every position bit. A newline or range end close needs
// no lookup; a limit stop adds a close step to the byte's own work; either
// waits further while the result register is still full.
// A result register sits on m_axis: the block keeps taking bytes while a
// result waits; only a second close waits until the first transfer is taken.
// Reset clears the position, count and widest line, restores the register
// defaults and leaves no line armed; glyph table entries hold no value until
// written. Configuration writes are always ready and take effect next cycle.
`timescale 1ns / 1ps
`default_nettype none
module text_pixel_position_measure_core
  import tppm_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // input stream
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] table_index, [15:8] table_width, [23:16] text_byte, [24] line_start,
  // [25] limit_mode, [41:26] pixel_limit, [47:42] zero
  input  wire logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  input  wire logic                      s_axis_tuser,   // [0] opcode
  input  wire logic                      s_axis_tlast,   // range_end
  // result stream
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // [15:0] x_position, [31:16] bytes_consumed, [47:32] widest_line
  output logic [OUT_TDATA_BITS-1:0]      m_axis_tdata,
  output logic [CAUSE_BITS-1:0]          m_axis_tuser,   // [1:0] stop_cause
  // configuration write channel
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire logic [TAB_BITS-1:0]       cfg_data_i
);

  ctrl_cmd_t             cmd;
  dp_status_t            sts;
  logic [FIELD_BITS-1:0] out_x, out_bytes, out_widest;
  stop_cause_e           out_cause;

  assign cfg_ready_o = 1'b1;

  // Sequencer: takes transfers while idle and steps each byte
  tppm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_opcode_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: unpack tdata fields straight into it
  tppm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .table_index_i (s_axis_tdata[7:0]),
    .table_width_i (s_axis_tdata[15:8]),
    .text_byte_i   (s_axis_tdata[23:16]),
    .line_start_i  (s_axis_tdata[24]),
    .limit_mode_i  (s_axis_tdata[25]),
    .pixel_limit_i (s_axis_tdata[41:26]),
    .range_end_i   (s_axis_tlast),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_x_o       (out_x),
    .out_bytes_o   (out_bytes),
    .out_widest_o  (out_widest),
    .out_cause_o   (out_cause)
  );

  assign m_axis_tdata = {out_widest, out_bytes, out_x};
  assign m_axis_tuser = out_cause;

  // A new result only ever appears from a line close
  a_rise_from_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(cmd.finish))
    else $error("result appeared without a line close");

  // The widest line reported covers the position of its own line
  a_widest_covers_x : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> (m_axis_tdata[47:32] >= m_axis_tdata[15:0]))
    else $error("widest line below reported position");

  // No byte is taken while a byte is still in work: a close, a commit or a tab remainder step
  a_no_take_in_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.finish || cmd.commit || cmd.div_step) |-> !s_axis_tready)
    else $error("input taken while a byte is still in work");

  // A close never overwrites a result that is still waiting
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("pending result overwritten");

endmodule
`default_nettype wire
